FILE: hdl/tcc_pkg.sv
// Shared types and constants for the tick clock and time converter.
package tcc_pkg;

    localparam int NS_W          = 30;
    localparam int OUT_W         = 31;
    localparam int TICK_BITS_DEF = 31;
    localparam int PROD_W_DEF    = ((TICK_BITS_DEF > OUT_W) ? TICK_BITS_DEF : OUT_W) + NS_W;
    localparam int MUL_STEPS     = NS_W;

    localparam logic [NS_W-1:0]  NS_PER_SEC  = 30'd1000000000;
    localparam logic [NS_W-1:0]  NS_MAX      = 30'd999999999;
    localparam logic [NS_W-1:0]  NANOS_RESET = 30'd16666689;
    localparam logic [OUT_W-1:0] OUT_MAX     = 31'h7FFFFFFF;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_READ      = 2'd1,
        MODE_CONV_TRUNC = 2'd2,
        MODE_CONV_CEIL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
        logic write;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/tcc_if.sv
// Request and response channel interfaces.
interface tcc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [29:0] elapsed_in_tick_ns;
    logic [30:0] in_seconds;
    logic [29:0] in_nanoseconds;

    modport source (output valid, mode, elapsed_in_tick_ns, in_seconds, in_nanoseconds,
                    input ready);
    modport sink   (input valid, mode, elapsed_in_tick_ns, in_seconds, in_nanoseconds,
                    output ready);
endinterface

interface tcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] current_ticks;
    logic [30:0] time_seconds;
    logic [29:0] time_nanos;
    logic [30:0] converted_ticks;
    logic        ticks_saturated;

    modport source (output valid, current_ticks, time_seconds, time_nanos, converted_ticks,
                    ticks_saturated, input ready);
    modport sink   (input valid, current_ticks, time_seconds, time_nanos, converted_ticks,
                    ticks_saturated, output ready);
endinterface

FILE: hdl/tcc_ctrl.sv
// Sequencer for the multiply, divide and result write steps.
module tcc_ctrl import tcc_pkg::*;
#(
    parameter int PW = PROD_W_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam int CW = $clog2(PW);

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = sts.is_tick ? ST_WRITE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(PW - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL:   cmd.mul_step = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_WRITE: cmd.write    = sts.out_free;
            default:  cmd          = '0;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_step, cmd.div_step, cmd.write}))
        else $error("more than one datapath command at once");

    a_write_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && !sts.out_free) |=> state_reg == ST_WRITE)
        else $error("result write abandoned while output busy");

endmodule

FILE: hdl/tcc_datapath.sv
// Tick counter, shift-add multiplier, restoring divider and result register.
module tcc_datapath import tcc_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF,
    parameter int PW        = ((TICK_BITS > OUT_W) ? TICK_BITS : OUT_W) + NS_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              cfg_we,
    input  logic [NS_W-1:0]   cfg_wdata,
    input  logic [1:0]        mode,
    input  logic [NS_W-1:0]   elapsed_in_tick_ns,
    input  logic [OUT_W-1:0]  in_seconds,
    input  logic [NS_W-1:0]   in_nanoseconds,
    tcc_rsp_if.source         rsp
);

    localparam logic [PW-1:0] LIMIT = (TICK_BITS < OUT_W)
        ? {{(PW - TICK_BITS){1'b0}}, {TICK_BITS{1'b1}}}
        : PW'(OUT_MAX);

    logic [NS_W-1:0]      npt_reg;
    logic [TICK_BITS-1:0] counter_reg;
    mode_t                mode_reg;
    logic [NS_W-1:0]      el_reg;
    logic [PW-1:0]        acc_reg;
    logic [PW-1:0]        mcand_reg;
    logic [NS_W-1:0]      mplier_reg;
    logic [NS_W-1:0]      dvsr_reg;
    logic [NS_W-1:0]      rem_reg;
    logic                 out_valid_reg;

    logic [NS_W-1:0]      npt_eff;
    mode_t                in_mode;
    logic [NS_W:0]        div_sh;
    logic                 div_ge;
    logic [NS_W:0]        div_diff;
    logic [NS_W:0]        ns_sum;
    logic                 ns_carry;
    logic [NS_W:0]        ns_fix;
    logic [PW-1:0]        secs;
    logic [PW-1:0]        conv;
    logic                 round_up;
    logic [TICK_BITS-1:0] cnt_inc;
    logic [PW-1:0]        cnt_ext;
    logic [PW-1:0]        cnt_inc_ext;

    assign npt_eff = (npt_reg == '0) ? NS_W'(1) : npt_reg;
    assign in_mode = mode_t'(mode);

    assign sts.is_tick  = (in_mode == MODE_TICK);
    assign sts.out_free = !out_valid_reg || rsp.ready;

    // One restoring divide step: bring down the next dividend bit.
    assign div_sh   = {rem_reg, acc_reg[PW-1]};
    assign div_ge   = (div_sh >= {1'b0, dvsr_reg});
    assign div_diff = div_sh - {1'b0, dvsr_reg};

    // Read-time finish: add elapsed ns, carry once into seconds.
    assign ns_sum   = {1'b0, rem_reg} + {1'b0, el_reg};
    assign ns_carry = (ns_sum >= {1'b0, NS_PER_SEC});
    assign ns_fix   = ns_carry ? (ns_sum - {1'b0, NS_PER_SEC}) : ns_sum;
    assign secs     = acc_reg + PW'(ns_carry);

    // Conversion finish: in ceiling mode, round up on a nonzero remainder.
    assign round_up = (mode_reg == MODE_CONV_CEIL) && (rem_reg != '0);
    assign conv     = acc_reg + PW'(round_up);

    // Wrap at the counter width before widening.
    assign cnt_inc     = counter_reg + 1'b1;
    assign cnt_ext     = PW'(counter_reg);
    assign cnt_inc_ext = PW'(cnt_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npt_reg       <= NANOS_RESET;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                npt_reg <= cfg_wdata;
            end
            if (cmd.write && mode_reg == MODE_TICK)
            begin
                counter_reg <= cnt_inc;
            end
            if (cmd.write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            el_reg   <= (elapsed_in_tick_ns > NS_MAX) ? NS_MAX : elapsed_in_tick_ns;
            rem_reg  <= '0;
            if (in_mode == MODE_READ)
            begin
                acc_reg    <= '0;
                mcand_reg  <= PW'(counter_reg);
                mplier_reg <= npt_eff;
                dvsr_reg   <= NS_PER_SEC;
            end
            else
            begin
                acc_reg    <= PW'(in_nanoseconds);
                mcand_reg  <= PW'(in_seconds);
                mplier_reg <= NS_PER_SEC;
                dvsr_reg   <= npt_eff;
            end
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[NS_W-1:1]};
        end
        else if (cmd.div_step)
        begin
            acc_reg <= {acc_reg[PW-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[NS_W-1:0] : div_sh[NS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            rsp.time_seconds    <= '0;
            rsp.time_nanos      <= '0;
            rsp.converted_ticks <= '0;
            rsp.ticks_saturated <= 1'b0;
            rsp.current_ticks   <= cnt_ext[OUT_W-1:0];
            case (mode_reg)
                MODE_TICK:
                begin
                    rsp.current_ticks <= cnt_inc_ext[OUT_W-1:0];
                end
                MODE_READ:
                begin
                    if (secs > PW'(OUT_MAX))
                    begin
                        rsp.time_seconds <= OUT_MAX;
                        rsp.time_nanos   <= NS_MAX;
                    end
                    else
                    begin
                        rsp.time_seconds <= secs[OUT_W-1:0];
                        rsp.time_nanos   <= ns_fix[NS_W-1:0];
                    end
                end
                MODE_CONV_TRUNC, MODE_CONV_CEIL:
                begin
                    if (conv > LIMIT)
                    begin
                        rsp.converted_ticks <= LIMIT[OUT_W-1:0];
                        rsp.ticks_saturated <= 1'b1;
                    end
                    else
                    begin
                        rsp.converted_ticks <= conv[OUT_W-1:0];
                    end
                end
                default:
                begin
                    rsp.current_ticks <= cnt_ext[OUT_W-1:0];
                end
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (!out_valid_reg || rsp.ready))
        else $error("result overwritten before transfer");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < dvsr_reg)
        else $error("divider remainder not below divisor");

    a_counter_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(counter_reg) |-> ($past(cmd.write) && $past(mode_reg) == MODE_TICK))
        else $error("tick counter moved without a tick item");

endmodule

FILE: hdl/tick_clock_time_converter_unit.sv
// Top level of the tick clock and time converter.
//
// Items arrive on req (valid/ready); one result per item leaves on rsp.
// Mode 0 counts one tick; mode 1 reads the time as counter * nanos_per_tick
// plus elapsed ns; modes 2 and 3 convert seconds plus ns into ticks,
// truncating or rounding up, clamped and flagged when out of range.
// nanos_per_tick is written through cfg_we/cfg_wdata; the user must do so
// only while the unit is idle, as the block itself does not enforce it.
// One item is worked on at a time. A tick item goes from idle straight to
// the write state; the next item is taken once the unit is back in idle.
// Modes 1 to 3 run a 30-step shift-add multiply and then a restoring
// divide of one quotient bit per cycle over the product width
// PW = max(TICK_BITS, 31) + 30, then reach the write state.
// Reset clears the tick counter, restores nanos_per_tick to 16666689 and
// empties the result register. A result held by a stalled receiver stays
// in the output register while the next item is taken and computed; that
// item's write waits until the held result transfers.
module tick_clock_time_converter_unit import tcc_pkg::*;
#(
    parameter int TICK_BITS = TICK_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [NS_W-1:0] cfg_wdata,
    tcc_req_if.sink         req,
    tcc_rsp_if.source       rsp
);

    localparam int PW = ((TICK_BITS > OUT_W) ? TICK_BITS : OUT_W) + NS_W;

    cmd_t cmd;
    sts_t sts;

    tcc_ctrl #(
        .PW (PW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcc_datapath #(
        .TICK_BITS (TICK_BITS),
        .PW        (PW)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .mode               (req.mode),
        .elapsed_in_tick_ns (req.elapsed_in_tick_ns),
        .in_seconds         (req.in_seconds),
        .in_nanoseconds     (req.in_nanoseconds),
        .rsp                (rsp)
    );

endmodule

FILE: sim/tick_clock_time_converter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tick clock and time converter unit.
module tick_clock_time_converter_unit_test;
    import tcc_pkg::*;

    localparam int TICK_BITS = TICK_BITS_DEF;
    localparam longint unsigned NS_SEC = 64'd1000000000;
    localparam longint unsigned COUNTER_MAX = (64'd1 << TICK_BITS) - 64'd1;
    localparam longint unsigned CONV_LIMIT = (COUNTER_MAX < OUT_MAX) ? COUNTER_MAX : OUT_MAX;
    localparam logic [NS_W-1:0] NANOS_ALT = 30'd16666922;
    localparam logic [NS_W-1:0] NS_ALL_ONES = {NS_W{1'b1}};
    localparam int PHASES = 7;
    localparam int RANDOM_PER_PHASE = 112;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        mode_t       mode;
        logic [29:0] elapsed_ns;
        logic [30:0] seconds;
        logic [29:0] nanoseconds;
    } clock_req_t;

    typedef struct packed {
        logic [30:0] current_ticks;
        logic [30:0] time_seconds;
        logic [29:0] time_nanos;
        logic [30:0] converted_ticks;
        logic        ticks_saturated;
    } clock_rsp_t;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [NS_W-1:0] cfg_wdata;

    tcc_req_if req_ch();
    tcc_rsp_if rsp_ch();

    tick_clock_time_converter_unit #(.TICK_BITS(TICK_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    clock_req_t      pending_requests[$];
    clock_rsp_t      expected_results[$];
    longint unsigned tick_len_model = NANOS_RESET;
    longint unsigned tick_count_model = 0;
    logic [NS_W-1:0] tick_len_now = NANOS_RESET;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_off_requests = 0;
    int              hold_off_served = 0;
    int              hold_off_left = 0;
    int              mismatch_count = 0;
    int              cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the clock model by one item and return the result it owes.
    function automatic clock_rsp_t predict_clock(clock_req_t item);
        clock_rsp_t      res;
        longint unsigned npt;
        longint unsigned whole_part;
        longint unsigned frac_part;
        longint unsigned frac_prod;
        longint unsigned secs;
        longint unsigned nanos;
        longint unsigned elapsed;
        longint unsigned total;
        longint unsigned quot;
        res = '0;
        npt = (tick_len_model == 0) ? 64'd1 : tick_len_model;
        case (item.mode)
            MODE_TICK:
                tick_count_model = (tick_count_model >= COUNTER_MAX) ? 64'd0
                                                                     : tick_count_model + 64'd1;
            MODE_READ:
            begin
                // split the count at one billion so no product overflows 64 bits
                whole_part = tick_count_model / NS_SEC;
                frac_part = tick_count_model % NS_SEC;
                frac_prod = frac_part * npt;
                secs = whole_part * npt + frac_prod / NS_SEC;
                nanos = frac_prod % NS_SEC;
                elapsed = (item.elapsed_ns > NS_MAX) ? NS_MAX : item.elapsed_ns;
                nanos = nanos + elapsed;
                if (nanos >= NS_SEC)
                begin
                    secs = secs + 1;
                    nanos = nanos - NS_SEC;
                end
                if (secs > OUT_MAX)
                begin
                    secs = OUT_MAX;
                    nanos = NS_MAX;
                end
                res.time_seconds = secs[30:0];
                res.time_nanos = nanos[29:0];
            end
            default:
            begin
                total = item.seconds * NS_SEC + item.nanoseconds;
                quot = total / npt;
                if (item.mode == MODE_CONV_CEIL && quot * npt < total)
                    quot = quot + 1;
                if (quot > CONV_LIMIT)
                begin
                    quot = CONV_LIMIT;
                    res.ticks_saturated = 1'b1;
                end
                res.converted_ticks = quot[30:0];
            end
        endcase
        res.current_ticks = tick_count_model[30:0];
        return res;
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    function automatic void queue_request(mode_t mode, logic [29:0] elapsed_ns,
                                          logic [30:0] seconds, logic [29:0] nanoseconds);
        clock_req_t item;
        item.mode = mode;
        item.elapsed_ns = elapsed_ns;
        item.seconds = seconds;
        item.nanoseconds = nanoseconds;
        pending_requests.push_back(item);
    endfunction

    function automatic clock_req_t random_request();
        clock_req_t      item;
        longint unsigned npt;
        longint unsigned total;
        longint unsigned secs;
        int              pick;
        npt = (tick_len_now == 0) ? 64'd1 : tick_len_now;
        // fields the mode ignores still carry noise
        item.elapsed_ns = 30'($urandom);
        item.seconds = 31'($urandom);
        item.nanoseconds = 30'($urandom);
        pick = $urandom_range(99);
        if (pick < 35)
            item.mode = MODE_TICK;
        else if (pick < 50)
        begin
            item.mode = MODE_READ;
            case ($urandom_range(3))
                0: item.elapsed_ns = '0;
                1: item.elapsed_ns = NS_MAX;
                2: item.elapsed_ns = 30'($urandom_range(999999999));
                default: ;
            endcase
        end
        else
        begin
            item.mode = (pick < 75) ? MODE_CONV_TRUNC : MODE_CONV_CEIL;
            case ($urandom_range(3))
                0:
                begin
                    // whole number of ticks, one nanosecond over at times
                    total = npt * $urandom_range(32'(((64'd1 << NS_W) - 2) / npt))
                            + $urandom_range(1);
                    item.seconds = '0;
                    item.nanoseconds = total[29:0];
                end
                1:
                begin
                    // straddle the saturation point
                    total = CONV_LIMIT * npt - npt + $urandom_range(32'(2 * npt));
                    secs = total / NS_SEC;
                    item.seconds = (secs > OUT_MAX) ? OUT_MAX : secs[30:0];
                    item.nanoseconds = 30'(total % NS_SEC);
                end
                2:
                begin
                    item.seconds = 31'($urandom_range(5));
                    item.nanoseconds = 30'($urandom_range(999999999));
                end
                default: ;
            endcase
        end
        return item;
    endfunction

    task automatic wait_until_drained();
        while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic program_tick_length(input logic [NS_W-1:0] value);
        // let the unit settle after its last result
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        tick_len_now = value;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        clock_req_t item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = pending_requests.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.mode <= item.mode;
                req_ch.elapsed_in_tick_ns <= item.elapsed_ns;
                req_ch.in_seconds <= item.seconds;
                req_ch.in_nanoseconds <= item.nanoseconds;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_off_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else if (hold_off_served != hold_off_requests)
        begin
            // hold off long enough for the unit to back up into its input
            hold_off_served <= hold_off_requests;
            hold_off_left <= HOLD_OFF_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : monitor
        clock_req_t seen_req;
        clock_rsp_t want;
        if (!rst_n)
        begin
            tick_len_model = NANOS_RESET;
            tick_count_model = 0;
        end
        else
        begin
            if (cfg_we)
                tick_len_model = cfg_wdata;
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.mode = mode_t'(req_ch.mode);
                seen_req.elapsed_ns = req_ch.elapsed_in_tick_ns;
                seen_req.seconds = req_ch.in_seconds;
                seen_req.nanoseconds = req_ch.in_nanoseconds;
                expected_results.push_back(predict_clock(seen_req));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual ticks %0d",
                             $time, rsp_ch.current_ticks);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("current_ticks", want.current_ticks, rsp_ch.current_ticks);
                    check_field("time_seconds", want.time_seconds, rsp_ch.time_seconds);
                    check_field("time_nanos", want.time_nanos, rsp_ch.time_nanos);
                    check_field("converted_ticks", want.converted_ticks,
                                rsp_ch.converted_ticks);
                    check_field("ticks_saturated", want.ticks_saturated,
                                rsp_ch.ticks_saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        longint unsigned limit_total;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = NANOS_RESET;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_TICK;
        req_ch.elapsed_in_tick_ns = '0;
        req_ch.in_seconds = '0;
        req_ch.in_nanoseconds = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 74;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items under the reset tick length
        queue_request(MODE_READ, '0, '0, '0);
        queue_request(MODE_READ, NS_MAX, '0, '0);
        queue_request(MODE_READ, NS_ALL_ONES, '0, '0);
        queue_request(MODE_CONV_TRUNC, '0, '0, '0);
        queue_request(MODE_CONV_CEIL, '0, '0, '0);
        queue_request(MODE_TICK, NS_ALL_ONES, OUT_MAX, NS_ALL_ONES);
        queue_request(MODE_TICK, '0, '0, '0);
        queue_request(MODE_TICK, '0, '0, '0);
        queue_request(MODE_READ, NS_MAX, '0, '0);
        queue_request(MODE_READ, NS_ALL_ONES, OUT_MAX, NS_ALL_ONES);
        queue_request(MODE_CONV_TRUNC, '0, 31'd1, '0);
        queue_request(MODE_CONV_CEIL, '0, 31'd1, '0);
        queue_request(MODE_CONV_CEIL, '0, '0, 30'(3 * NANOS_RESET));
        queue_request(MODE_CONV_TRUNC, '0, '0, NS_ALL_ONES);
        queue_request(MODE_CONV_CEIL, '0, '0, NS_ALL_ONES);
        queue_request(MODE_CONV_CEIL, '0, '0, 30'd1);
        queue_request(MODE_CONV_TRUNC, '0, OUT_MAX, NS_ALL_ONES);
        queue_request(MODE_CONV_CEIL, NS_ALL_ONES, OUT_MAX, NS_MAX);
        // largest time that still fits, then just past it
        limit_total = CONV_LIMIT * NANOS_RESET;
        queue_request(MODE_CONV_TRUNC, '0, 31'(limit_total / NS_SEC),
                      30'(limit_total % NS_SEC));
        limit_total = limit_total + 1;
        queue_request(MODE_CONV_CEIL, '0, 31'(limit_total / NS_SEC),
                      30'(limit_total % NS_SEC));
        limit_total = limit_total + NANOS_RESET;
        queue_request(MODE_CONV_TRUNC, '0, 31'(limit_total / NS_SEC),
                      30'(limit_total % NS_SEC));
        queue_request(MODE_READ, '0, '0, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase >= 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (phase >= 2)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 30;
            end
            wait_until_drained();
            case (phase)
                1: program_tick_length(NANOS_ALT);
                2: program_tick_length('0);
                3: program_tick_length(NS_MAX);
                4: program_tick_length(NS_ALL_ONES);
                5: program_tick_length(30'd1);
                6: program_tick_length(30'($urandom_range(999999999, 1)));
                default: ;
            endcase
            if (phase == PRESSURE_PHASE)
                hold_off_requests = hold_off_requests + 1;
            repeat (RANDOM_PER_PHASE)
                pending_requests.push_back(random_request());
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
